### rtl/alle_pkg.sv
package alle_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_INSERT     = 3'd2,
        OP_ERASE      = 3'd3,
        OP_READ       = 3'd4,
        OP_CLEAR      = 3'd5
    } t_opcode;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK_REQ,
        S_WALK_WAIT,
        S_WALK_STEP,
        S_APPLY,
        S_APPLY2,
        S_READ_WAIT,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input beat
        logic walk_init;   // cursor <- head, index <- 0
        logic link_rd;     // read link of cursor
        logic walk_adv;    // cursor <- read link, index++
        logic val_rd;      // read value of cursor
        logic do_add_back;
        logic do_add_front;
        logic do_insert;   // insert after cursor
        logic do_erase_head;
        logic erase_rd;    // read link of victim (cursor's next)
        logic do_erase_mid;
        logic do_clear;
        logic set_status;
        logic [1:0] status;
        logic set_read;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       ins_range_bad;
        logic       pos_range_bad;
        logic       pos_zero;
        logic       pos_is_len;
        logic       walk_done;      // index == target
    } t_stat;

endpackage

### rtl/alle_datapath.sv
module alle_datapath #(
    parameter int CAPACITY   = 128,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_opcode,
    input  logic [6:0]         i_position,
    input  logic signed [31:0] i_item_value,
    input  alle_pkg::t_cmd     i_cmd,
    output alle_pkg::t_stat    o_stat,
    output logic signed [31:0] o_read_value,
    output logic [7:0]         o_element_count,
    output logic [1:0]         o_status
);
    import alle_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = AW + 1;
    localparam int CW = (PW > 7) ? PW : 7;
    localparam logic [PW-1:0] NULL_P = PW'(CAPACITY);

    logic [VALUE_BITS-1:0] r_vals  [CAPACITY];
    logic [PW-1:0]         r_links [CAPACITY];
    logic [AW-1:0]         r_freed [CAPACITY];

    logic [PW-1:0] r_head, r_tail, r_freed_cnt, r_fresh, r_len;
    logic [2:0]    r_op;
    logic [6:0]    r_pos;
    logic [VALUE_BITS-1:0] r_val;
    logic [PW-1:0] r_cur, r_idx, r_victim;
    logic [PW-1:0] r_link_q;
    logic [VALUE_BITS-1:0] r_val_q;
    logic [AW-1:0] r_freed_q;
    logic [1:0]    r_stat;
    logic [31:0]   r_rd;
    logic [31:0]   r_out_rd;
    logic [7:0]    r_out_cnt;
    logic [1:0]    r_out_st;

    logic [PW-1:0] target;
    logic [PW-1:0] pos_w;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] len_c;
    logic [AW-1:0] new_slot;
    logic          use_freed;

    assign pos_w  = PW'(r_pos);
    assign pos_c  = CW'(r_pos);
    assign len_c  = CW'(r_len);
    assign target = (r_op == OP_READ) ? pos_w : pos_w - PW'(1);
    assign use_freed = (r_freed_cnt != '0);
    assign new_slot  = use_freed ? r_freed_q : r_fresh[AW-1:0];

    assign o_stat.op            = r_op;
    assign o_stat.full          = !use_freed && (r_fresh >= NULL_P);
    assign o_stat.ins_range_bad = pos_c > len_c;
    assign o_stat.pos_range_bad = pos_c >= len_c;
    assign o_stat.pos_zero      = (r_pos == '0);
    assign o_stat.pos_is_len    = (pos_c == len_c);
    assign o_stat.walk_done     = (r_idx == target);

    // freed stack top kept registered for slot allocation
    always_ff @(posedge i_clk) begin
        r_freed_q <= r_freed[AW'(r_freed_cnt - PW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_pos <= i_position;
            r_val <= VALUE_BITS'(i_item_value);
        end
        if (i_cmd.walk_init) begin
            r_cur <= r_head;
            r_idx <= '0;
        end
        if (i_cmd.link_rd) r_link_q <= r_links[r_cur[AW-1:0]];
        if (i_cmd.erase_rd) r_link_q <= r_links[r_victim[AW-1:0]];
        if (i_cmd.walk_adv) begin
            r_cur <= r_link_q;
            r_idx <= r_idx + PW'(1);
        end
        if (i_cmd.val_rd) r_val_q <= r_vals[r_cur[AW-1:0]];
        if (i_cmd.link_rd) r_victim <= r_links[r_cur[AW-1:0]];
        if (i_cmd.set_read) r_rd <= 32'(r_val_q);
        if (i_cmd.load) r_rd <= '0;
        if (i_cmd.set_status) r_stat <= i_cmd.status;
        if (i_cmd.load) r_stat <= ST_OK;
        if (i_cmd.out_load) begin
            r_out_rd  <= r_rd;
            r_out_cnt <= 8'(r_len);
            r_out_st  <= r_stat;
        end
        // memory writes
        if (i_cmd.do_add_back || i_cmd.do_add_front || i_cmd.do_insert) begin
            r_vals[new_slot] <= r_val;
        end
        if (i_cmd.do_add_back) begin
            r_links[new_slot] <= NULL_P;
            if (r_head != NULL_P) r_links[r_tail[AW-1:0]] <= PW'(new_slot);
        end
        if (i_cmd.do_add_front) r_links[new_slot] <= r_head;
        if (i_cmd.do_insert) begin
            r_links[new_slot] <= r_victim;
            r_links[r_cur[AW-1:0]] <= PW'(new_slot);
        end
        if (i_cmd.do_erase_mid) r_links[r_cur[AW-1:0]] <= r_link_q;
        if (i_cmd.do_erase_head) r_freed[AW'(r_freed_cnt)] <= r_head[AW-1:0];
        if (i_cmd.do_erase_mid) r_freed[AW'(r_freed_cnt)] <= r_victim[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NULL_P;
            r_tail      <= NULL_P;
            r_freed_cnt <= '0;
            r_fresh     <= '0;
            r_len       <= '0;
        end else begin
            if (i_cmd.do_add_back || i_cmd.do_add_front || i_cmd.do_insert) begin
                r_len <= r_len + PW'(1);
                if (use_freed) r_freed_cnt <= r_freed_cnt - PW'(1);
                else           r_fresh     <= r_fresh + PW'(1);
            end
            if (i_cmd.do_add_back) begin
                if (r_head == NULL_P) r_head <= PW'(new_slot);
                r_tail <= PW'(new_slot);
            end
            if (i_cmd.do_add_front) begin
                if (r_head == NULL_P) r_tail <= PW'(new_slot);
                r_head <= PW'(new_slot);
            end
            if (i_cmd.do_erase_head) begin
                r_head <= r_link_q;
                if (r_link_q == NULL_P) r_tail <= NULL_P;
            end
            if (i_cmd.do_erase_mid && r_victim == r_tail) r_tail <= r_cur;
            if (i_cmd.do_erase_head || i_cmd.do_erase_mid) begin
                r_len <= r_len - PW'(1);
                if (r_freed_cnt < NULL_P) r_freed_cnt <= r_freed_cnt + PW'(1);
            end
            if (i_cmd.do_clear) begin
                r_head      <= NULL_P;
                r_tail      <= NULL_P;
                r_freed_cnt <= '0;
                r_fresh     <= '0;
                r_len       <= '0;
            end
        end
    end

    assign o_read_value    = r_out_rd;
    assign o_element_count = r_out_cnt;
    assign o_status        = r_out_st;
endmodule

### rtl/alle_ctrl.sv
module alle_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_stall,
    output logic            o_valid,
    input  alle_pkg::t_stat i_stat,
    output alle_pkg::t_cmd  o_cmd
);
    import alle_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                o_cmd.walk_init = 1'b1;
                case (i_stat.op) inside
                    OP_PUSH_BACK, OP_PUSH_FRONT: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else n_state = S_APPLY;
                    end
                    OP_INSERT: begin
                        if (i_stat.ins_range_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else if (i_stat.pos_zero || i_stat.pos_is_len) n_state = S_APPLY;
                        else n_state = S_WALK_REQ;
                    end
                    OP_ERASE, OP_READ: begin
                        if (i_stat.pos_range_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else if (i_stat.op == OP_ERASE && i_stat.pos_zero) begin
                            n_state = S_WALK_WAIT;
                        end else n_state = S_WALK_REQ;
                    end
                    OP_CLEAR: o_cmd.do_clear = 1'b1;
                    default: ;
                endcase
            end
            S_WALK_REQ: begin
                if (i_stat.walk_done) begin
                    if (i_stat.op == OP_READ) begin
                        o_cmd.val_rd = 1'b1;
                        n_state = S_READ_WAIT;
                    end else begin
                        o_cmd.link_rd = 1'b1;
                        n_state = S_APPLY;
                    end
                end else begin
                    o_cmd.link_rd = 1'b1;
                    n_state = S_WALK_STEP;
                end
            end
            S_WALK_STEP: begin
                o_cmd.walk_adv = 1'b1;
                n_state = S_WALK_REQ;
            end
            S_WALK_WAIT: begin
                // erase at head: fetch head's link
                o_cmd.link_rd = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = S_DONE;
                case (i_stat.op)
                    OP_PUSH_BACK: o_cmd.do_add_back = 1'b1;
                    OP_PUSH_FRONT: o_cmd.do_add_front = 1'b1;
                    OP_INSERT: begin
                        if (i_stat.pos_zero) o_cmd.do_add_front = 1'b1;
                        else if (i_stat.pos_is_len) o_cmd.do_add_back = 1'b1;
                        else o_cmd.do_insert = 1'b1;
                    end
                    OP_ERASE: begin
                        if (i_stat.pos_zero) o_cmd.do_erase_head = 1'b1;
                        else begin
                            o_cmd.erase_rd = 1'b1;
                            n_state = S_APPLY2;
                        end
                    end
                    default: ;
                endcase
            end
            S_APPLY2: begin
                o_cmd.do_erase_mid = 1'b1;
                n_state = S_DONE;
            end
            S_READ_WAIT: begin
                o_cmd.set_read = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### rtl/array_linked_list_engine_top.sv
// Push and insert at either end go from the decision straight to the update; clear,
// unknown opcodes and errors finish at the decision; erase at the head fetches the
// head's link first; read, erase and insert in the middle walk the list link by link.
// Throughput: one command at a time; the next beat is taken once the result
// is registered, while that result may still wait downstream.
// Reset (synchronous, active low) empties the list; node memories are not cleared.
module array_linked_list_engine_top #(
    parameter int CAPACITY   = 128,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_opcode,
    input  logic [6:0]         i_position,
    input  logic signed [31:0] i_item_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_read_value,
    output logic [7:0]         o_element_count,
    output logic [1:0]         o_status
);
    import alle_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    alle_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_stall, .o_valid,
        .i_stat(stat), .o_cmd(cmd)
    );

    alle_datapath #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_opcode, .i_position, .i_item_value,
        .i_cmd(cmd), .o_stat(stat), .o_read_value, .o_element_count, .o_status
    );
endmodule

### rtl/alle_checker.sv
module alle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_read_value,
    input logic [7:0]  o_element_count,
    input logic [1:0]  o_status
);
    import alle_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_value) && $stable(o_status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_RANGE || o_status == ST_FULL))
        else $error("bad status code");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_element_count <= 8'd128)
        else $error("count out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_read_value == 32'd0)
        else $error("read value on error");
endmodule

bind array_linked_list_engine_top alle_checker u_chk (.*);

### bench/array_linked_list_engine_top_tb.sv
`timescale 1ns / 100ps

module array_linked_list_engine_top_tb;
    import alle_pkg::*;

    localparam int CAP = 128;
    localparam logic [7:0] NIL = 8'd128;
    localparam int LIMIT = 3_000_000;
    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [6:0]         position;
        logic signed [31:0] item_value;
    } t_cmd_beat;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [7:0]         element_count;
        logic [1:0]         status;
    } t_result;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         in_opcode;
    logic [6:0]         in_position;
    logic signed [31:0] in_item_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_read_value;
    logic [7:0]         out_element_count;
    logic [1:0]         out_status;

    array_linked_list_engine_top u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_stall(in_stall),
        .i_opcode(in_opcode),
        .i_position(in_position),
        .i_item_value(in_item_value),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_read_value(out_read_value),
        .o_element_count(out_element_count),
        .o_status(out_status)
    );

    // list model state
    logic [31:0] node_val [CAP];
    logic [7:0]  node_next [CAP];
    logic [7:0]  free_stack [CAP];
    logic [7:0]  head_ptr, tail_ptr;
    int          free_depth, fresh_used, list_len;

    t_cmd_beat cmd_queue [$];
    t_result   result_queue [$];
    bit        failed;
    bit        drain_hold;
    int        cycle_count;
    int        gap_left;
    int        stall_left;

    function automatic logic [7:0] slot_at(int idx);
        logic [7:0] s;
        s = head_ptr;
        for (int i = 0; i < idx; i++) s = node_next[s];
        return s;
    endfunction

    function automatic logic [7:0] alloc_node(logic [31:0] v, logic [7:0] nxt);
        logic [7:0] s;
        if (free_depth > 0) begin
            free_depth--;
            s = free_stack[free_depth];
        end else begin
            s = fresh_used[7:0];
            fresh_used++;
        end
        node_val[s] = v;
        node_next[s] = nxt;
        list_len++;
        return s;
    endfunction

    function automatic void link_back(logic [31:0] v);
        logic [7:0] s;
        s = alloc_node(v, NIL);
        if (head_ptr == NIL) head_ptr = s;
        else node_next[tail_ptr] = s;
        tail_ptr = s;
    endfunction

    function automatic void link_front(logic [31:0] v);
        logic [7:0] s;
        s = alloc_node(v, head_ptr);
        if (head_ptr == NIL) tail_ptr = s;
        head_ptr = s;
    endfunction

    function automatic t_result apply_command(t_cmd_beat c);
        t_result r;
        logic [7:0] prev, victim, s;
        bit full;
        int pos;
        r = '0;
        pos = c.position;
        full = (free_depth == 0) && (fresh_used >= CAP);
        case (c.opcode) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (full) r.status = ST_FULL;
                else if (c.opcode == OP_PUSH_BACK) link_back(c.item_value);
                else link_front(c.item_value);
            end
            OP_INSERT: begin
                if (pos > list_len) r.status = ST_RANGE;
                else if (full) r.status = ST_FULL;
                else if (pos == 0) link_front(c.item_value);
                else if (pos == list_len) link_back(c.item_value);
                else begin
                    prev = slot_at(pos - 1);
                    s = alloc_node(c.item_value, node_next[prev]);
                    node_next[prev] = s;
                end
            end
            OP_ERASE: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else begin
                    if (pos == 0) begin
                        victim = head_ptr;
                        head_ptr = node_next[victim];
                        if (head_ptr == NIL) tail_ptr = NIL;
                    end else begin
                        prev = slot_at(pos - 1);
                        victim = node_next[prev];
                        node_next[prev] = node_next[victim];
                        if (victim == tail_ptr) tail_ptr = prev;
                    end
                    free_stack[free_depth] = victim;
                    free_depth++;
                    list_len--;
                end
            end
            OP_READ: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else r.read_value = node_val[slot_at(pos)];
            end
            OP_CLEAR: begin
                head_ptr = NIL;
                tail_ptr = NIL;
                free_depth = 0;
                fresh_used = 0;
                list_len = 0;
            end
            default: ;
        endcase
        r.element_count = list_len[7:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void queue_cmd(logic [2:0] op, int pos, logic [31:0] v);
        t_cmd_beat c;
        c.opcode = op;
        c.position = pos[6:0];
        c.item_value = v;
        cmd_queue = {cmd_queue, c};
    endfunction

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) result_queue = {result_queue, apply_command(
                {in_opcode, in_position, in_item_value})};
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_queue.size() > 0 && !drain_hold) begin
                in_valid <= 1'b1;
                {in_opcode, in_position, in_item_value} <= cmd_queue.pop_front();
                gap_left <= pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (result_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    failed = 1'b1;
                end else begin
                    want = result_queue.pop_front();
                    if (out_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, out_read_value);
                        failed = 1'b1;
                    end
                    if (out_element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, out_element_count);
                        failed = 1'b1;
                    end
                    if (out_status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, out_status);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                out_stall <= 1'b0;
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int op, len_est;
        logic [31:0] v;
        failed = 1'b0;
        drain_hold = 1'b0;
        cycle_count = 0;
        head_ptr = NIL;
        tail_ptr = NIL;
        free_depth = 0;
        fresh_used = 0;
        list_len = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_opcode = '0;
        in_position = '0;
        in_item_value = '0;
        out_stall = 1'b0;

        // errors on an empty list, then the basic operations
        queue_cmd(OP_READ, 0, 0);
        queue_cmd(OP_ERASE, 0, 0);
        queue_cmd(OP_INSERT, 1, 32'h1);
        queue_cmd(OP_PUSH_BACK, 0, 32'h7FFF_FFFF);
        queue_cmd(OP_PUSH_FRONT, 127, 32'h8000_0000);
        queue_cmd(OP_INSERT, 0, 32'hFFFF_FFFF);
        queue_cmd(OP_INSERT, 3, 32'h0);
        queue_cmd(OP_INSERT, 2, 32'h5555_AAAA);
        queue_cmd(OP_INSERT, 6, 32'h1);
        queue_cmd(OP_READ, 2, 0);
        queue_cmd(OP_READ, 4, 0);
        queue_cmd(OP_READ, 5, 0);
        queue_cmd(OP_ERASE, 4, 0);
        queue_cmd(OP_ERASE, 1, 0);
        queue_cmd(OP_ERASE, 0, 0);
        queue_cmd(OP_PUSH_BACK, 0, 32'hAAAA_5555);
        queue_cmd(OP_UNDEF_LO, 127, 32'h1234_5678);
        queue_cmd(OP_UNDEF_HI, 0, 0);
        queue_cmd(OP_CLEAR, 0, 0);
        queue_cmd(OP_READ, 0, 0);
        // fill the store to the top, overflow it, then read the far end
        for (int i = 0; i < CAP; i++) queue_cmd(OP_PUSH_BACK, 0, $urandom());
        queue_cmd(OP_PUSH_FRONT, 0, 1);
        queue_cmd(OP_INSERT, 127, 2);
        queue_cmd(OP_INSERT, 0, 2);
        queue_cmd(OP_READ, 127, 0);
        queue_cmd(OP_ERASE, 127, 0);
        queue_cmd(OP_ERASE, 60, 0);
        queue_cmd(OP_INSERT, 127, 32'h0F0F_0F0F);
        queue_cmd(OP_READ, 127, 0);
        queue_cmd(OP_CLEAR, 0, 0);

        // random traffic; keep the list mostly short, with a few deep phases
        len_est = 0;
        for (int i = 0; i < 1400; i++) begin
            v = $urandom();
            op = $urandom_range(0, 99);
            if ((i / 250) % 3 == 2) op = (op < 45) ? 0 : op;
            if (op < 20) begin
                queue_cmd(OP_PUSH_BACK, $urandom_range(0, 127), v);
                len_est++;
            end else if (op < 35) begin
                queue_cmd(OP_PUSH_FRONT, $urandom_range(0, 127), v);
                len_est++;
            end else if (op < 55) begin
                queue_cmd(OP_INSERT, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 127) :
                          $urandom_range(0, (len_est > 127) ? 127 : len_est), v);
                len_est++;
            end else if (op < 72) begin
                queue_cmd(OP_ERASE, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 127) :
                          $urandom_range(0, (len_est > 127) ? 127 : len_est), v);
                if (len_est > 0) len_est--;
            end else if (op < 95) begin
                queue_cmd(OP_READ, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 127) :
                          $urandom_range(0, (len_est > 127) ? 127 : len_est), v);
            end else if (op < 98) begin
                queue_cmd(OP_CLEAR, $urandom_range(0, 127), v);
                len_est = 0;
            end else begin
                queue_cmd(($urandom_range(0, 1) == 0) ? OP_UNDEF_LO : OP_UNDEF_HI,
                          $urandom_range(0, 127), v);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // hold the sender once until every result is back
        wait (cmd_queue.size() < 700);
        @(posedge clk);
        drain_hold <= 1'b1;
        wait (!in_valid && result_queue.size() == 0);
        @(posedge clk);
        drain_hold <= 1'b0;

        wait (cmd_queue.size() == 0 && !in_valid);
        wait (result_queue.size() == 0);
        repeat (300) @(posedge clk);
        if (failed || result_queue.size() != 0) begin
            $display("Mismatches found");
        end else begin
            $display("No mismatches found");
        end
        $finish;
    end

endmodule
